FILE: hw/rtl/key_sequence_detector_assert.svh
// assertion macros of the key sequence detector rtl
`ifndef KEY_SEQUENCE_DETECTOR_ASSERT_SVH
`define KEY_SEQUENCE_DETECTOR_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define KSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked out of reset
`define KSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define KSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define KSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/ksd_pkg.sv
// types, constants and helper functions of the key sequence detector
package ksd_pkg;

   localparam int MAX_SEQUENCE = 16;
   localparam int MAX_DIGITS   = 2;

   localparam int KEY_W   = 8;
   localparam int TICK_W  = 31;
   localparam int WORD_W  = 64;
   localparam int LEN_W   = $clog2(MAX_SEQUENCE + 1);
   localparam int POS_W   = $clog2(MAX_SEQUENCE);
   localparam int CNT_W   = 2;
   localparam int TO_W    = 16;
   localparam int INDEX_W = 3;

   // register indexes
   localparam logic [INDEX_W-1:0] CSR_SEQ_LOW   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_SEQ_HIGH  = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_SEQ_LEN   = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_DIGITS    = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_TIMEOUT   = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_LONG_TO   = 3'd5;
   localparam logic [INDEX_W-1:0] CSR_KEYS_MOVE = 3'd6;

   localparam logic [LEN_W-1:0] LEN_RESET     = LEN_W'(1);
   localparam logic [TO_W-1:0]  TIMEOUT_RESET = TO_W'(140);

   localparam logic [KEY_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [KEY_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [KEY_W-1:0] CHAR_CASE    = 8'h20;
   localparam logic [KEY_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [KEY_W-1:0] CHAR_NINE    = 8'h39;

   typedef struct packed {
      logic [WORD_W-1:0] seq_low;
      logic [WORD_W-1:0] seq_high;
      logic [LEN_W-1:0]  seq_len;
      logic [CNT_W-1:0]  digit_count;
      logic [TO_W-1:0]   timeout;
      logic              long_timeout;
      logic              keys_move;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_code;
      logic [TICK_W-1:0] now_tick;
   } item_type;

   typedef struct packed {
      logic             matched;
      logic [KEY_W-1:0] first_digit;
      logic [KEY_W-1:0] second_digit;
      logic             swallow_key;
   } result_type;

   // ascii a-z folded onto A-Z
   function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] c);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         return c - CHAR_CASE;
      end
      return c;
   endfunction

   function automatic logic [KEY_W-1:0] seq_char(input logic [WORD_W-1:0] low,
                                                 input logic [WORD_W-1:0] high,
                                                 input logic [POS_W-1:0]  idx);
      logic [2*WORD_W-1:0] both;
      both = {high, low};
      return both[idx*KEY_W +: KEY_W];
   endfunction

endpackage

FILE: hw/rtl/ksd_if.sv
// handshake channel interfaces of the key sequence detector
interface ksd_req_if;
   import ksd_pkg::*;
   logic              valid;
   logic              ready;
   logic [KEY_W-1:0]  key_code;
   logic [TICK_W-1:0] now_tick;
   modport source (output valid, output key_code, output now_tick, input ready);
   modport sink (input valid, input key_code, input now_tick, output ready);
endinterface

interface ksd_rsp_if;
   import ksd_pkg::*;
   logic             valid;
   logic             ready;
   logic             matched;
   logic [KEY_W-1:0] first_digit;
   logic [KEY_W-1:0] second_digit;
   logic             swallow_key;
   modport source (output valid, output matched, output first_digit,
                   output second_digit, output swallow_key, input ready);
   modport sink (input valid, input matched, input first_digit,
                 input second_digit, input swallow_key, output ready);
endinterface

interface ksd_csr_if;
   import ksd_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] reg_index;
   logic [WORD_W-1:0]  wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: hw/rtl/ksd_csr.sv
// configuration register file of the key sequence detector
module ksd_csr (
   input  logic             clock,
   input  logic             reset,
   ksd_csr_if.sink          csr,
   output ksd_pkg::cfg_type cfg
);
   import ksd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.reg_index)
            CSR_SEQ_LOW:   cfg_in.seq_low      = csr.wdata;
            CSR_SEQ_HIGH:  cfg_in.seq_high     = csr.wdata;
            CSR_SEQ_LEN:   cfg_in.seq_len      = csr.wdata[LEN_W-1:0];
            CSR_DIGITS:    cfg_in.digit_count  = csr.wdata[CNT_W-1:0];
            CSR_TIMEOUT:   cfg_in.timeout      = csr.wdata[TO_W-1:0];
            CSR_LONG_TO:   cfg_in.long_timeout = csr.wdata[0];
            CSR_KEYS_MOVE: cfg_in.keys_move    = csr.wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seq_low      <= '0;
         cfg_ff.seq_high     <= '0;
         cfg_ff.seq_len      <= LEN_RESET;
         cfg_ff.digit_count  <= '0;
         cfg_ff.timeout      <= TIMEOUT_RESET;
         cfg_ff.long_timeout <= 1'b0;
         cfg_ff.keys_move    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

FILE: hw/rtl/ksd_core.sv
// match state and per-key step logic of the key sequence detector
module ksd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ksd_pkg::item_type   item,
   input  ksd_pkg::cfg_type    cfg,
   output ksd_pkg::result_type result,
   output logic                idle_state
);
   import ksd_pkg::*;

   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  digits_ff, digits_in;
   logic [TICK_W-1:0] last_tick_ff, last_tick_in;
   logic [KEY_W-1:0]  store_ff [MAX_DIGITS];
   logic [KEY_W-1:0]  store_in [MAX_DIGITS];

   logic [LEN_W-1:0]  len_eff;
   logic [CNT_W-1:0]  need;
   logic [TO_W-1:0]   limit;
   logic [TICK_W:0]   diff;
   logic [KEY_W-1:0]  key_f;
   logic              abort;

   assign len_eff = (cfg.seq_len > LEN_W'(MAX_SEQUENCE)) ? LEN_W'(MAX_SEQUENCE) : cfg.seq_len;
   assign need    = (cfg.digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                           : cfg.digit_count;
   assign limit   = cfg.long_timeout ? cfg.timeout : (cfg.timeout >> 1);
   assign key_f   = fold_case(item.key_code);
   // tick going back shows up as the sign bit
   assign diff    = {1'b0, item.now_tick} - {1'b0, last_tick_ff};
   assign idle_state = (pos_ff == '0) && (digits_ff == '0);

   always_comb begin
      pos_in       = pos_ff;
      digits_in    = digits_ff;
      last_tick_in = item.now_tick;
      store_in     = store_ff;
      abort        = 1'b0;
      result       = '0;

      if (last_tick_ff != '0 && !diff[TICK_W] && diff > (TICK_W+1)'(limit)) begin
         pos_in    = '0;
         digits_in = '0;
      end

      if (pos_in < len_eff) begin
         if (key_f == fold_case(seq_char(cfg.seq_low, cfg.seq_high, pos_in[POS_W-1:0]))) begin
            pos_in = pos_in + LEN_W'(1);
         end else if (key_f == fold_case(seq_char(cfg.seq_low, cfg.seq_high, '0))) begin
            pos_in = LEN_W'(1);
         end else begin
            pos_in = '0;
         end
         digits_in = '0;
         result.swallow_key = (pos_in > LEN_W'(1)) && !cfg.keys_move;
      end else if (digits_in < need) begin
         if (item.key_code < CHAR_ZERO || item.key_code > CHAR_NINE) begin
            abort        = 1'b1;
            pos_in       = '0;
            digits_in    = '0;
            last_tick_in = '0;
         end else begin
            store_in[digits_in[0]] = item.key_code;
            digits_in = digits_in + CNT_W'(1);
         end
      end

      if (!abort && pos_in >= len_eff && digits_in >= need) begin
         result.matched      = 1'b1;
         result.first_digit  = (need > CNT_W'(0)) ? store_in[0] : '0;
         result.second_digit = (need > CNT_W'(1)) ? store_in[1] : '0;
         pos_in       = '0;
         digits_in    = '0;
         last_tick_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         digits_ff    <= '0;
         last_tick_ff <= '0;
         store_ff     <= '{default: '0};
      end else if (advance) begin
         pos_ff       <= pos_in;
         digits_ff    <= digits_in;
         last_tick_ff <= last_tick_in;
         store_ff     <= store_in;
      end
   end
endmodule

FILE: hw/rtl/key_sequence_detector.sv
// top level of the key sequence detector
//
//  channel  | dir | handshake   | payload
//  req_bus  | in  | valid/ready | key_code[7:0], now_tick[30:0]
//  rsp_bus  | out | valid/ready | matched, first_digit[7:0], second_digit[7:0], swallow_key
//  csr_bus  | in  | valid/ready | reg_index[2:0], wdata[63:0]
//
// one request per cycle sustained while rsp_bus is ready; a result passes through the
// input register, then step logic into the result register
// reset clears match progress, timer and registers to their defaults
// a stalled result holds the result register, and the input register still
// takes one more request behind it; csr writes are always taken
module key_sequence_detector (
   input logic      clock,
   input logic      reset,
   ksd_req_if.sink  req_bus,
   ksd_rsp_if.source rsp_bus,
   ksd_csr_if.sink  csr_bus
);
   import ksd_pkg::*;

   `include "key_sequence_detector_assert.svh"

   cfg_type    cfg;
   result_type step_result;
   logic       core_idle;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance;
   logic       req_take;

   ksd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   ksd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .result     (step_result),
      .idle_state (core_idle)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.key_code <= req_bus.key_code;
         in_item_ff.now_tick <= req_bus.now_tick;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.matched      = out_ff.matched;
   assign rsp_bus.first_digit  = out_ff.first_digit;
   assign rsp_bus.second_digit = out_ff.second_digit;
   assign rsp_bus.swallow_key  = out_ff.swallow_key;

   `KSD_ASSERT_IMP(a_full_blocks_req, clock, reset, in_valid_ff && out_valid_ff && !rsp_bus.ready, !req_bus.ready)
   `KSD_ASSERT_NEXT(a_step_lands, clock, reset, advance, out_valid_ff)
   `KSD_ASSERT_NEXT(a_match_clears, clock, reset, advance && step_result.matched, core_idle)
   `KSD_ASSERT_IMP(a_nomatch_no_digits, clock, reset, out_valid_ff && !out_ff.matched, out_ff.first_digit == '0 && out_ff.second_digit == '0)
endmodule

FILE: sim/key_sequence_detector_tb.sv
// self-checking testbench for the key sequence detector: random keystrokes against a predictor
`timescale 1ns / 100ps
module key_sequence_detector_tb;
   import ksd_pkg::*;

   localparam logic [INDEX_W-1:0] CSR_UNUSED   = 3'd7;
   localparam logic [KEY_W-1:0]   CHAR_UPPER_A = 8'h41;
   localparam logic [KEY_W-1:0]   CHAR_UPPER_Z = 8'h5A;

   localparam int LATENCY_CYCLES = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_KEYS    = 850;
   localparam int KEYS_PER_PHASE = 105;
   localparam int RUN_LIMIT_NS   = 1000000;
   localparam int MAX_PRINTS     = 200;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_type;

   logic clock;
   logic reset;

   ksd_req_if req_bus ();
   ksd_rsp_if rsp_bus ();
   ksd_csr_if csr_bus ();

   key_sequence_detector u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   item_type    pending_keys[$];
   result_type  expected_results[$];
   int          keys_queued    = 0;
   int          keys_in_flight = 0;
   int          results_seen   = 0;
   int          mismatch_count = 0;
   logic        req_taken      = 1'b0;
   int          burst_left     = 0;
   int          gap_left       = 0;
   ready_mode_type ready_mode  = READY_ALWAYS;
   int          ready_timer    = 0;
   logic [7:0]  stall_pattern  = 8'hA5;
   logic        hold_start     = 1'b0;
   logic        hold_off       = 1'b0;
   logic [TICK_W-1:0] cur_tick = '0;

   // shadow of the detector: registers and match progress
   cfg_type           cfg_shadow;
   logic [LEN_W-1:0]  seq_pos;
   logic [CNT_W-1:0]  digits_taken;
   logic [31:0]       last_tick;
   logic [KEY_W-1:0]  digit_buf [2];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("key_sequence_detector_tb: FAIL");
      $finish;
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_start);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   function automatic logic [KEY_W-1:0] upper_key(input logic [KEY_W-1:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CHAR_CASE : c;
   endfunction

   function automatic logic [KEY_W-1:0] seq_byte(input int idx);
      logic [2*WORD_W-1:0] chars;
      chars = {cfg_shadow.seq_high, cfg_shadow.seq_low};
      return chars[(idx % 16) * 8 +: 8];
   endfunction

   function automatic int seq_len_eff();
      return (cfg_shadow.seq_len > MAX_SEQUENCE) ? MAX_SEQUENCE : int'(cfg_shadow.seq_len);
   endfunction

   function automatic int digits_eff();
      return (cfg_shadow.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(cfg_shadow.digit_count);
   endfunction

   function automatic void apply_reg(input logic [INDEX_W-1:0] idx,
                                     input logic [WORD_W-1:0] data);
      case (idx)
         CSR_SEQ_LOW:   cfg_shadow.seq_low      = data;
         CSR_SEQ_HIGH:  cfg_shadow.seq_high     = data;
         CSR_SEQ_LEN:   cfg_shadow.seq_len      = data[LEN_W-1:0];
         CSR_DIGITS:    cfg_shadow.digit_count  = data[CNT_W-1:0];
         CSR_TIMEOUT:   cfg_shadow.timeout      = data[TO_W-1:0];
         CSR_LONG_TO:   cfg_shadow.long_timeout = data[0];
         CSR_KEYS_MOVE: cfg_shadow.keys_move    = data[0];
         default: ;
      endcase
   endfunction

   function automatic result_type predict_key(input logic [KEY_W-1:0] key,
                                              input logic [TICK_W-1:0] now);
      result_type r;
      int len, need;
      logic [31:0] limit, diff;
      r = '0;
      len = seq_len_eff();
      need = digits_eff();
      limit = cfg_shadow.long_timeout ? {16'd0, cfg_shadow.timeout}
                                      : {17'd0, cfg_shadow.timeout[TO_W-1:1]};
      // a stored tick of zero means the idle timer is not running
      if (last_tick != 32'd0) begin
         diff = {1'b0, now} - last_tick;
         if (!diff[31] && diff > limit) begin
            seq_pos = '0;
            digits_taken = '0;
         end
      end
      last_tick = {1'b0, now};
      if (seq_pos < len) begin
         if (upper_key(key) == upper_key(seq_byte(seq_pos)))
            seq_pos = seq_pos + 1'b1;
         else
            seq_pos = (upper_key(key) == upper_key(seq_byte(0))) ? LEN_W'(1) : LEN_W'(0);
         digits_taken = '0;
         if (seq_pos > 1 && !cfg_shadow.keys_move) r.swallow_key = 1'b1;
      end else if (digits_taken < need) begin
         if (key < CHAR_ZERO || key > CHAR_NINE) begin
            seq_pos = '0;
            digits_taken = '0;
            last_tick = '0;
            return '0;
         end
         digit_buf[digits_taken[0]] = key;
         digits_taken = digits_taken + 1'b1;
      end
      if (seq_pos >= len && digits_taken >= need) begin
         r.matched = 1'b1;
         r.first_digit = (need > 0) ? digit_buf[0] : '0;
         r.second_digit = (need > 1) ? digit_buf[1] : '0;
         seq_pos = '0;
         digits_taken = '0;
         last_tick = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("result %0d: %s is %0h, predicted %0h", results_seen, field, got, want);
      mismatch_count++;
   endtask

   // request driver: bursts of random length with random gaps
   always @(negedge clock) begin : drive_keys
      item_type next_key;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_keys.size() > 0) begin
            next_key = pending_keys.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.key_code <= next_key.key_code;
            req_bus.now_tick <= next_key.now_tick;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      logic take;
      if (ready_timer == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_timer = $urandom_range(20, 80);
         stall_pattern = 8'($urandom);
      end else begin
         ready_timer--;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (ready_mode)
         READY_ALWAYS:  take = 1'b1;
         READY_COIN:    take = 1'($urandom_range(0, 1));
         READY_PATTERN: take = stall_pattern[0];
         default:       take = ($urandom_range(0, 3) == 0);
      endcase
      rsp_bus.ready <= !reset && !hold_off && take;
   end

   // monitor: register writes, accepted requests and results, all seen at the rising edge
   always @(posedge clock) begin : check_results
      result_type want;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding", 8'd0, 8'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.matched !== want.matched)
                  report_mismatch("matched", rsp_bus.matched, want.matched);
               if (rsp_bus.first_digit !== want.first_digit)
                  report_mismatch("first_digit", rsp_bus.first_digit, want.first_digit);
               if (rsp_bus.second_digit !== want.second_digit)
                  report_mismatch("second_digit", rsp_bus.second_digit, want.second_digit);
               if (rsp_bus.swallow_key !== want.swallow_key)
                  report_mismatch("swallow_key", rsp_bus.swallow_key, want.swallow_key);
               results_seen++;
               keys_in_flight--;
            end
         end
         if (csr_bus.valid && csr_bus.ready)
            apply_reg(csr_bus.reg_index, csr_bus.wdata);
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(predict_key(req_bus.key_code, req_bus.now_tick));
      end
   end

   task automatic queue_key(input logic [KEY_W-1:0] key, input logic [TICK_W-1:0] tick);
      item_type it;
      it.key_code = key;
      it.now_tick = tick;
      cur_tick = tick;
      pending_keys.push_back(it);
      keys_in_flight++;
      keys_queued++;
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // unused upper bits of narrow registers sometimes carry garbage
   function automatic logic [WORD_W-1:0] with_junk(input logic [WORD_W-1:0] v, input int w);
      logic [WORD_W-1:0] mask;
      mask = (64'd1 << w) - 64'd1;
      if ($urandom_range(0, 1) == 0) return v & mask;
      return ({$urandom, $urandom} & ~mask) | (v & mask);
   endfunction

   task automatic load_config(input cfg_type c);
      write_reg(CSR_SEQ_LOW, c.seq_low);
      write_reg(CSR_SEQ_HIGH, c.seq_high);
      write_reg(CSR_SEQ_LEN, with_junk(64'(c.seq_len), LEN_W));
      write_reg(CSR_DIGITS, with_junk(64'(c.digit_count), CNT_W));
      write_reg(CSR_TIMEOUT, with_junk(64'(c.timeout), TO_W));
      write_reg(CSR_LONG_TO, with_junk(64'(c.long_timeout), 1));
      write_reg(CSR_KEYS_MOVE, with_junk(64'(c.keys_move), 1));
   endtask

   // every request answered and the pipeline flushed
   task automatic wait_idle();
      wait (keys_in_flight == 0);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] random_seq_char();
      case ($urandom_range(0, 4))
         0:       return CHAR_UPPER_A + KEY_W'($urandom_range(0, 25));
         1:       return CHAR_LOWER_A + KEY_W'($urandom_range(0, 25));
         2:       return CHAR_ZERO + KEY_W'($urandom_range(0, 9));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] vary_case(input logic [KEY_W-1:0] c);
      if ($urandom_range(0, 1) == 0) return c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return c - CHAR_CASE;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CHAR_CASE;
      return c;
   endfunction

   // next tick: mostly within the idle limit, sometimes past it, backwards, zero or anywhere
   function automatic logic [TICK_W-1:0] step_tick();
      int unsigned limit, pick;
      limit = cfg_shadow.long_timeout ? cfg_shadow.timeout : (cfg_shadow.timeout >> 1);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         cur_tick = cur_tick + TICK_W'($urandom_range(0, limit));
      else if (pick < 80)
         cur_tick = cur_tick + TICK_W'(limit + 1 + $urandom_range(0, limit));
      else if (pick < 86)
         cur_tick = cur_tick - TICK_W'($urandom_range(1, 1000));
      else if (pick < 90)
         cur_tick = '0;
      else if (pick < 95)
         cur_tick = TICK_W'($urandom);
      return cur_tick;
   endfunction

   // mostly well-formed entries with random case, some broken ones and plain noise
   task automatic queue_attempt();
      int len, need, cut, kind;
      len = seq_len_eff();
      need = digits_eff();
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         for (int i = 0; i < len; i++)
            queue_key(($urandom_range(0, 24) == 0) ? KEY_W'($urandom) : vary_case(seq_byte(i)),
                      step_tick());
         for (int i = 0; i < need; i++)
            queue_key(($urandom_range(0, 11) == 0) ? KEY_W'($urandom)
                                                   : CHAR_ZERO + KEY_W'($urandom_range(0, 9)),
                      step_tick());
      end else if (kind < 9) begin
         cut = $urandom_range(0, len);
         for (int i = 0; i < cut; i++)
            queue_key(vary_case(seq_byte(i)), step_tick());
         queue_key(KEY_W'($urandom), step_tick());
      end else begin
         cut = $urandom_range(1, 4);
         for (int i = 0; i < cut; i++)
            queue_key(KEY_W'($urandom), step_tick());
      end
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      for (int i = 0; i < 8; i++) begin
         c.seq_low[i*8 +: 8] = random_seq_char();
         c.seq_high[i*8 +: 8] = random_seq_char();
      end
      if ($urandom_range(0, 3) == 0) c.seq_low = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) c.seq_high = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:          c.seq_len = '0;
         1, 2, 3, 4,
         5, 6:       c.seq_len = LEN_W'($urandom_range(1, 4));
         7, 8:       c.seq_len = LEN_W'($urandom_range(5, 16));
         default:    c.seq_len = LEN_W'($urandom_range(17, 31));
      endcase
      c.digit_count = CNT_W'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0:       c.timeout = TO_W'(1);
         1:       c.timeout = '1;
         default: c.timeout = TO_W'($urandom_range(2, 400));
      endcase
      c.long_timeout = 1'($urandom_range(0, 1));
      c.keys_move = 1'($urandom_range(0, 1));
      return c;
   endfunction

   initial begin
      cfg_type c;
      int random_start, phase_start;
      req_bus.valid = 1'b0;
      req_bus.key_code = '0;
      req_bus.now_tick = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wdata = '0;
      cfg_shadow = '0;
      cfg_shadow.seq_len = LEN_RESET;
      cfg_shadow.timeout = TIMEOUT_RESET;
      seq_pos = '0;
      digits_taken = '0;
      last_tick = '0;
      digit_buf[0] = '0;
      digit_buf[1] = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one-character sequence of code zero
      queue_key(8'h00, 31'd5);
      queue_key(8'h41, 31'd6);
      wait_idle();

      // out-of-range index must be ignored
      write_reg(CSR_UNUSED, '1);
      c = '0;
      c.seq_low = 64'h0000_0000_217A_5978;
      c.seq_len = LEN_W'(4);
      c.digit_count = CNT_W'(2);
      c.timeout = TO_W'(100);
      c.long_timeout = 1'b1;
      load_config(c);
      // full entry with mixed case and two digits
      queue_key(8'h58, 31'd10);
      queue_key(8'h79, 31'd20);
      queue_key(8'h5A, 31'd30);
      queue_key(8'h21, 31'd40);
      queue_key(8'h34, 31'd50);
      queue_key(8'h32, 31'd60);
      // repeated first char restarts at one, then a gap past the limit
      queue_key(8'h78, 31'd100);
      queue_key(8'h58, 31'd110);
      queue_key(8'h79, 31'd400);
      // non-digit parameter aborts
      queue_key(8'h78, 31'd500);
      queue_key(8'h59, 31'd510);
      queue_key(8'h7A, 31'd520);
      queue_key(8'h21, 31'd530);
      queue_key(8'h61, 31'd540);
      // tick going back, a key at tick zero, then the largest tick
      queue_key(8'h78, 31'd1000);
      queue_key(8'h79, 31'd500);
      queue_key(8'h7A, 31'd510);
      queue_key(8'h21, 31'd520);
      queue_key(CHAR_ZERO, 31'd0);
      queue_key(CHAR_NINE, 31'h7FFF_FFFF);
      wait_idle();

      // empty sequence, oversized digit count, zero idle limit
      c = '0;
      c.digit_count = CNT_W'(3);
      c.timeout = TO_W'(1);
      c.keys_move = 1'b1;
      load_config(c);
      queue_key(CHAR_ZERO, 31'd5);
      queue_key(CHAR_NINE, 31'd5);
      queue_key(8'h35, 31'd6);
      queue_key(8'h37, 31'd7);
      queue_key(8'h71, 31'd7);
      wait_idle();

      random_start = keys_queued;
      for (int phase = 0; keys_queued - random_start < RANDOM_KEYS; phase++) begin
         c = random_config();
         if (phase == 0) begin
            // oversized length over all-ones characters, longest limit
            c.seq_low = '1;
            c.seq_high = '1;
            c.seq_len = '1;
            c.digit_count = CNT_W'(2);
            c.timeout = '1;
            c.long_timeout = 1'b1;
            c.keys_move = 1'b0;
         end else if (phase == 1) begin
            c.seq_len = LEN_W'(MAX_SEQUENCE);
            c.digit_count = '0;
            c.timeout = TO_W'(1);
            c.long_timeout = 1'b0;
         end
         load_config(c);
         if (phase == 3) hold_start = 1'b1;
         phase_start = keys_queued;
         while (keys_queued - phase_start < KEYS_PER_PHASE / 2)
            queue_attempt();
         if (phase == 5) wait_idle();
         while (keys_queued - phase_start < KEYS_PER_PHASE)
            queue_attempt();
         wait_idle();
      end

      if (expected_results.size() != 0)
         report_mismatch("results never returned", 8'(expected_results.size()), 8'd0);
      if (mismatch_count == 0) begin
         $display("key_sequence_detector_tb: PASS");
      end else begin
         $display("key_sequence_detector_tb: FAIL");
      end
      $finish;
   end

endmodule
